>>> hdl/citp_pkg.sv
// Shared types, codes and decode tables for the card information tuple parser.
package citp_pkg;

    // Record kinds carried on the result channel
    typedef enum logic [2:0] {
        REC_HEADER = 3'd0,
        REC_DEVICE = 3'd1,
        REC_FUNC   = 3'd2,
        REC_CONFIG = 3'd3,
        REC_END    = 3'd4
    } rec_kind_t;

    // Tuple codes and special byte values
    localparam logic [7:0] CODE_END      = 8'hFF;
    localparam logic [7:0] CODE_DEVICE   = 8'h01;
    localparam logic [7:0] CODE_DEVICE_A = 8'h17;
    localparam logic [7:0] CODE_FUNCID   = 8'h21;
    localparam logic [7:0] CODE_CONFIG   = 8'h1A;
    localparam logic [7:0] LINK_LAST     = 8'hFF;
    localparam logic [7:0] DEV_ID_END    = 8'hFF;
    localparam logic [7:0] DEV_ID_NULL   = 8'h00;
    localparam logic [3:0] TYPE_EXT      = 4'hE;
    localparam logic [2:0] SPEED_EXT     = 3'h7;

    localparam int SPEED_W = 27;
    localparam int SIZE_W  = 29;

    // One result record
    typedef struct packed {
        rec_kind_t          kind;
        logic [7:0]         code;
        logic [7:0]         link;
        logic               attr;
        logic [7:0]         dev_type;
        logic [SPEED_W-1:0] speed;
        logic [SIZE_W-1:0]  size;
        logic [7:0]         func;
        logic [31:0]        base;
        logic [15:0]        mask;
        logic [7:0]         last;
    } citp_rec_t;

    // Values decoded from a single device-tuple byte
    typedef struct packed {
        logic [SPEED_W-1:0] std_speed;
        logic [SPEED_W-1:0] ext_speed;
        logic [SIZE_W-1:0]  size;
    } citp_dev_dec_t;

    // Standard speed code to nanoseconds
    function automatic logic [SPEED_W-1:0] speed_ns_of(input logic [2:0] code);
        logic [SPEED_W-1:0] ns;
        case (code)
            3'd1:    ns = SPEED_W'(250);
            3'd2:    ns = SPEED_W'(200);
            3'd3:    ns = SPEED_W'(150);
            3'd4:    ns = SPEED_W'(100);
            default: ns = '0;
        endcase
        return ns;
    endfunction

    // Extended speed mantissa, times ten
    function automatic logic [6:0] mant_of(input logic [3:0] m);
        logic [6:0] v;
        case (m)
            4'd1:    v = 7'd10;
            4'd2:    v = 7'd12;
            4'd3:    v = 7'd13;
            4'd4:    v = 7'd15;
            4'd5:    v = 7'd20;
            4'd6:    v = 7'd25;
            4'd7:    v = 7'd30;
            4'd8:    v = 7'd35;
            4'd9:    v = 7'd40;
            4'd10:   v = 7'd45;
            4'd11:   v = 7'd50;
            4'd12:   v = 7'd55;
            4'd13:   v = 7'd60;
            4'd14:   v = 7'd70;
            4'd15:   v = 7'd80;
            default: v = 7'd0;
        endcase
        return v;
    endfunction

    // Mantissa over ten, truncated, for the 1 ns exponent
    function automatic logic [3:0] mant_div10_of(input logic [3:0] m);
        logic [3:0] v;
        case (m)
            4'd1, 4'd2, 4'd3, 4'd4: v = 4'd1;
            4'd5, 4'd6:             v = 4'd2;
            4'd7, 4'd8:             v = 4'd3;
            4'd9, 4'd10:            v = 4'd4;
            4'd11, 4'd12:           v = 4'd5;
            4'd13:                  v = 4'd6;
            4'd14:                  v = 4'd7;
            4'd15:                  v = 4'd8;
            default:                v = 4'd0;
        endcase
        return v;
    endfunction

    // Exponent scale over ten, for exponents 1..7
    function automatic logic [19:0] exp_div10_of(input logic [2:0] e);
        logic [19:0] v;
        case (e)
            3'd1:    v = 20'd1;
            3'd2:    v = 20'd10;
            3'd3:    v = 20'd100;
            3'd4:    v = 20'd1000;
            3'd5:    v = 20'd10000;
            3'd6:    v = 20'd100000;
            3'd7:    v = 20'd1000000;
            default: v = 20'd0;
        endcase
        return v;
    endfunction

endpackage

>>> hdl/card_info_tuple_parser.sv
// Card information tuple parser: walks the tuple chain one byte per transaction.
// Path: an accepted byte passes the input register and then the result register, where
//   its record can be taken; a byte that yields no record leaves nothing.
// Throughput: one byte per cycle while the result side keeps taking records.
// Reset: asynchronous; clears the walk to expect a tuple code and empties both stages.
module card_info_tuple_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic [7:0]  cis_byte,
    input  logic        restart,
    output logic        rec_valid,
    input  logic        rec_ready,
    output logic [2:0]  rec_kind,
    output logic [7:0]  tuple_code,
    output logic [7:0]  link_len,
    output logic        attr_space,
    output logic [7:0]  device_type,
    output logic [26:0] speed_ns,
    output logic [28:0] size_bytes,
    output logic [7:0]  func_code,
    output logic [31:0] cfg_base,
    output logic [15:0] cfg_mask,
    output logic [7:0]  cfg_last
);
    import citp_pkg::*;

    typedef enum logic [3:0] {
        PH_CODE, PH_LINK, PH_SKIP, PH_DEV_ID, PH_DEV_NULLSIZE, PH_DEV_XSPEED,
        PH_DEV_AESPEED, PH_DEV_XTYPE, PH_DEV_SIZE, PH_FUNC, PH_CFG_SIZE,
        PH_CFG_LAST, PH_CFG_BASE, PH_CFG_MASK, PH_END_PENDING, PH_DONE
    } phase_t;

    // Input stage
    logic       in_valid_reg;
    logic [7:0] byte_reg;
    logic       restart_reg;

    // Parser state
    phase_t             phase_reg, phase_next;
    logic [7:0]         cur_code_reg, cur_code_next;
    logic [7:0]         body_left_reg, body_left_next;
    logic               last_tuple_reg, last_tuple_next;
    logic [4:0]         field_count_reg, field_count_next;
    logic [SPEED_W-1:0] speed_acc_reg, speed_acc_next;
    logic [7:0]         type_acc_reg, type_acc_next;
    logic [5:0]         size_codes_reg, size_codes_next;
    logic [31:0]        base_acc_reg, base_acc_next;
    logic [15:0]        mask_acc_reg, mask_acc_next;
    logic [7:0]         last_index_reg, last_index_next;

    // Result stage
    logic      out_valid_reg;
    logic      emit;
    citp_rec_t out_rec_reg, rec_next;

    logic          advance;
    logic          fire;
    logic [4:0]    fc_inc;
    logic [7:0]    body_dec;
    citp_dev_dec_t dev_dec;

    assign advance    = !out_valid_reg || rec_ready;
    assign fire       = in_valid_reg && advance;
    assign item_ready = !in_valid_reg || advance;

    citp_field_dec u_field_dec (
        .data (byte_reg),
        .dec  (dev_dec)
    );

    // Next-state and record decode for the registered byte
    always_comb
    begin
        phase_next       = phase_reg;
        cur_code_next    = cur_code_reg;
        body_left_next   = body_left_reg;
        last_tuple_next  = last_tuple_reg;
        field_count_next = field_count_reg;
        speed_acc_next   = speed_acc_reg;
        type_acc_next    = type_acc_reg;
        size_codes_next  = size_codes_reg;
        base_acc_next    = base_acc_reg;
        mask_acc_next    = mask_acc_reg;
        last_index_next  = last_index_reg;
        emit             = 1'b0;
        rec_next         = '0;
        fc_inc           = field_count_reg + 5'd1;
        body_dec         = body_left_reg - 8'd1;

        if (restart_reg)
        begin
            phase_next       = PH_CODE;
            cur_code_next    = '0;
            body_left_next   = '0;
            last_tuple_next  = 1'b0;
            field_count_next = '0;
            speed_acc_next   = '0;
            type_acc_next    = '0;
            size_codes_next  = '0;
            base_acc_next    = '0;
            mask_acc_next    = '0;
            last_index_next  = '0;
        end
        else
        begin
            case (phase_reg)
                PH_DONE:
                begin
                end
                PH_END_PENDING:
                begin
                    emit          = 1'b1;
                    rec_next.kind = REC_END;
                    rec_next.code = CODE_END;
                    phase_next    = PH_DONE;
                end
                PH_CODE:
                begin
                    if (byte_reg == CODE_END)
                    begin
                        emit          = 1'b1;
                        rec_next.kind = REC_END;
                        rec_next.code = CODE_END;
                        phase_next    = PH_DONE;
                    end
                    else
                    begin
                        cur_code_next = byte_reg;
                        phase_next    = PH_LINK;
                    end
                end
                PH_LINK:
                begin
                    emit             = 1'b1;
                    rec_next.kind    = REC_HEADER;
                    rec_next.code    = cur_code_reg;
                    rec_next.link    = byte_reg;
                    last_tuple_next  = (byte_reg == LINK_LAST);
                    body_left_next   = byte_reg;
                    field_count_next = '0;
                    if (byte_reg == 8'd0)
                        phase_next = PH_CODE;
                    else if (cur_code_reg == CODE_DEVICE || cur_code_reg == CODE_DEVICE_A)
                        phase_next = PH_DEV_ID;
                    else if (cur_code_reg == CODE_FUNCID)
                        phase_next = PH_FUNC;
                    else if (cur_code_reg == CODE_CONFIG)
                        phase_next = PH_CFG_SIZE;
                    else
                        phase_next = PH_SKIP;
                end
                default:
                begin
                    // Body bytes
                    case (phase_reg)
                        PH_DEV_ID:
                        begin
                            if (byte_reg == DEV_ID_END)
                            begin
                                phase_next = PH_SKIP;
                            end
                            else if (byte_reg == DEV_ID_NULL)
                            begin
                                phase_next = PH_DEV_NULLSIZE;
                            end
                            else
                            begin
                                type_acc_next = {4'b0, byte_reg[7:4]};
                                if (byte_reg[2:0] == SPEED_EXT)
                                begin
                                    phase_next = PH_DEV_XSPEED;
                                end
                                else
                                begin
                                    speed_acc_next = dev_dec.std_speed;
                                    phase_next = (byte_reg[7:4] == TYPE_EXT) ?
                                                 PH_DEV_XTYPE : PH_DEV_SIZE;
                                end
                            end
                        end
                        PH_DEV_NULLSIZE:
                        begin
                            phase_next = PH_DEV_ID;
                        end
                        PH_DEV_XSPEED:
                        begin
                            if (byte_reg[7])
                            begin
                                speed_acc_next = '0;
                                phase_next     = PH_DEV_AESPEED;
                            end
                            else
                            begin
                                speed_acc_next = dev_dec.ext_speed;
                                phase_next = (type_acc_reg == {4'b0, TYPE_EXT}) ?
                                             PH_DEV_XTYPE : PH_DEV_SIZE;
                            end
                        end
                        PH_DEV_AESPEED:
                        begin
                            phase_next = (type_acc_reg == {4'b0, TYPE_EXT}) ?
                                         PH_DEV_XTYPE : PH_DEV_SIZE;
                        end
                        PH_DEV_XTYPE:
                        begin
                            type_acc_next = byte_reg;
                            phase_next    = PH_DEV_SIZE;
                        end
                        PH_DEV_SIZE:
                        begin
                            emit              = 1'b1;
                            rec_next.kind     = REC_DEVICE;
                            rec_next.code     = cur_code_reg;
                            rec_next.attr     = (cur_code_reg == CODE_DEVICE_A);
                            rec_next.dev_type = type_acc_reg;
                            rec_next.speed    = speed_acc_reg;
                            rec_next.size     = dev_dec.size;
                            phase_next        = PH_DEV_ID;
                        end
                        PH_FUNC:
                        begin
                            emit          = 1'b1;
                            rec_next.kind = REC_FUNC;
                            rec_next.code = cur_code_reg;
                            rec_next.func = byte_reg;
                            phase_next    = PH_SKIP;
                        end
                        PH_CFG_SIZE:
                        begin
                            size_codes_next = byte_reg[5:0];
                            phase_next      = PH_CFG_LAST;
                        end
                        PH_CFG_LAST:
                        begin
                            last_index_next  = byte_reg;
                            base_acc_next    = '0;
                            mask_acc_next    = '0;
                            field_count_next = '0;
                            phase_next       = PH_CFG_BASE;
                        end
                        PH_CFG_BASE:
                        begin
                            base_acc_next = base_acc_reg |
                                ({24'b0, byte_reg} << {field_count_reg[1:0], 3'b0});
                            field_count_next = fc_inc;
                            if (fc_inc >= ({3'b0, size_codes_reg[1:0]} + 5'd1))
                            begin
                                field_count_next = '0;
                                phase_next       = PH_CFG_MASK;
                            end
                        end
                        PH_CFG_MASK:
                        begin
                            if (field_count_reg < 5'd2)
                            begin
                                mask_acc_next = mask_acc_reg |
                                    (field_count_reg[0] ? {byte_reg, 8'b0} : {8'b0, byte_reg});
                            end
                            field_count_next = fc_inc;
                            if (fc_inc >= ({1'b0, size_codes_reg[5:2]} + 5'd1))
                            begin
                                emit             = 1'b1;
                                rec_next.kind    = REC_CONFIG;
                                rec_next.code    = cur_code_reg;
                                rec_next.base    = base_acc_reg;
                                rec_next.mask    = (field_count_reg < 5'd2) ?
                                    (mask_acc_reg | (field_count_reg[0] ?
                                        {byte_reg, 8'b0} : {8'b0, byte_reg})) :
                                    mask_acc_reg;
                                rec_next.last    = last_index_reg;
                                field_count_next = '0;
                                phase_next       = PH_SKIP;
                            end
                        end
                        default:
                        begin
                        end
                    endcase

                    // Every body byte counts against the link length
                    body_left_next = body_dec;
                    if (body_dec == 8'd0)
                    begin
                        phase_next = last_tuple_reg ? PH_END_PENDING : PH_CODE;
                    end
                end
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            in_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
        begin
            byte_reg    <= cis_byte;
            restart_reg <= restart;
        end
    end

    // Parser state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_CODE;
            cur_code_reg    <= '0;
            body_left_reg   <= '0;
            last_tuple_reg  <= 1'b0;
            field_count_reg <= '0;
            speed_acc_reg   <= '0;
            type_acc_reg    <= '0;
            size_codes_reg  <= '0;
            base_acc_reg    <= '0;
            mask_acc_reg    <= '0;
            last_index_reg  <= '0;
            out_valid_reg   <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= fire && emit;
            if (fire)
            begin
                phase_reg       <= phase_next;
                cur_code_reg    <= cur_code_next;
                body_left_reg   <= body_left_next;
                last_tuple_reg  <= last_tuple_next;
                field_count_reg <= field_count_next;
                speed_acc_reg   <= speed_acc_next;
                type_acc_reg    <= type_acc_next;
                size_codes_reg  <= size_codes_next;
                base_acc_reg    <= base_acc_next;
                mask_acc_reg    <= mask_acc_next;
                last_index_reg  <= last_index_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && emit)
        begin
            out_rec_reg <= rec_next;
        end
    end

    // Result ports
    assign rec_valid   = out_valid_reg;
    assign rec_kind    = out_rec_reg.kind;
    assign tuple_code  = out_rec_reg.code;
    assign link_len    = out_rec_reg.link;
    assign attr_space  = out_rec_reg.attr;
    assign device_type = out_rec_reg.dev_type;
    assign speed_ns    = out_rec_reg.speed;
    assign size_bytes  = out_rec_reg.size;
    assign func_code   = out_rec_reg.func;
    assign cfg_base    = out_rec_reg.base;
    assign cfg_mask    = out_rec_reg.mask;
    assign cfg_last    = out_rec_reg.last;

    // A free result slot never blocks the input side
    a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> item_ready)
        else $error("input stalled with empty result register");

    // Once the chain has ended, bytes produce no records
    a_done_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && phase_reg == PH_DONE) |=> !rec_valid)
        else $error("record emitted after chain end");

    // Device records only come from device tuples
    a_dev_code: assert property (@(posedge clk) disable iff (!rst_n)
        (rec_valid && rec_kind == REC_DEVICE) |->
        (tuple_code == CODE_DEVICE || tuple_code == CODE_DEVICE_A))
        else $error("device record from a non-device tuple");

    // Chain end records carry the end code and no link
    a_end_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (rec_valid && rec_kind == REC_END) |-> (tuple_code == CODE_END && link_len == 8'd0))
        else $error("malformed chain end record");

endmodule

>>> hdl/citp_field_dec.sv
// Device-tuple byte decode: standard speed, extended speed and device size.
module citp_field_dec (
    input  logic [7:0]             data,
    output citp_pkg::citp_dev_dec_t dec
);
    import citp_pkg::*;

    logic [6:0]         mant;
    logic [19:0]        scale;
    logic [SPEED_W-1:0] ext_prod;
    logic [5:0]         units;

    // Extended speed: mantissa * 10^exp / 10, exact above exponent zero
    always_comb
    begin
        mant     = mant_of(data[6:3]);
        scale    = exp_div10_of(data[2:0]);
        ext_prod = {20'b0, mant} * {7'b0, scale};
    end

    // Size: (units + 1) * 512 * 4^scale
    always_comb
    begin
        units = {1'b0, data[7:3]} + 6'd1;
    end

    always_comb
    begin
        dec.std_speed = speed_ns_of(data[2:0]);
        if (data[2:0] == 3'd0)
        begin
            dec.ext_speed = {23'b0, mant_div10_of(data[6:3])};
        end
        else
        begin
            dec.ext_speed = ext_prod;
        end
        dec.size = SIZE_W'({units, 9'b0}) << {data[2:0], 1'b0};
    end

endmodule
